>>> src/assert_macros.svh
// Assertion macros for the button debounce RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BDE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/bde_pkg.sv
// Shared types, codes and constants for the button debounce event generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package bde_pkg;

   localparam int BUTTON_COUNT_DEFAULT = 16;
   localparam int RAW_W      = 16;
   localparam int INDEX_W    = 4;
   localparam int CNT_W      = 8;
   localparam int THR_W      = 8;
   localparam int DELAY_W    = 10;
   localparam int UNITS_W    = 8;
   localparam int IDLE_W     = 22;
   localparam int PTIMER_W   = 15;
   localparam int BTIMER_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   localparam logic [CNT_W-1:0]    CNT_MAX      = '1;
   localparam logic [IDLE_W-1:0]   IDLE_MAX     = '1;
   localparam logic [PTIMER_W-1:0] HOLD_UNIT_MS = 15'd50;

   localparam logic [THR_W-1:0]   RST_THRESHOLD = 8'd4;
   localparam logic [DELAY_W-1:0] RST_RELEASE   = 10'd150;
   localparam logic [UNITS_W-1:0] RST_HOLD      = 8'd40;
   localparam logic [IDLE_W-1:0]  RST_IDLE      = 22'd300000;
   localparam logic [INDEX_W-1:0] RST_START     = 4'd0;
   localparam logic [INDEX_W-1:0] RST_SELECT    = 4'd1;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SELECT    = 3'd5;

   typedef enum logic [1:0] {
      BTN_RELEASED = 2'd0,
      BTN_PRESSED  = 2'd1,
      BTN_LONG     = 2'd2
   } btn_state_type;

   typedef enum logic [1:0] {
      EVT_BUTTON = 2'd0,
      EVT_POWER  = 2'd1,
      EVT_BIOS   = 2'd2
   } event_kind_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_COUNT,
      OP_SCAN,
      OP_RELCHK,
      OP_HOLD_START,
      OP_HOLD_SELECT,
      OP_TICK_STEP,
      OP_TICK_POWER,
      OP_TICK_BIOS,
      OP_FLUSH
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_COUNT,
      S_SCAN,
      S_RELCHK,
      S_HOLD_START,
      S_HOLD_SELECT,
      S_TICK_STEP,
      S_TICK_POWER,
      S_TICK_BIOS,
      S_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      op_type               op;
      logic [INDEX_W-1:0]   button;
   } cmd_type;

   typedef struct packed {
      event_kind_type       kind;
      logic [INDEX_W-1:0]   button;
      logic                 pressed;
   } result_type;

endpackage

`default_nettype wire

>>> src/bde_ctrl.sv
// Sequencer for the button debounce block: walks each request through its steps.
// Depends on bde_pkg and assert_macros.svh; drives bde_datapath by commands.
`default_nettype none
`include "assert_macros.svh"

module bde_ctrl
   import bde_pkg::*;
#(
   parameter int BUTTON_COUNT = BUTTON_COUNT_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   input  wire logic    req_kind,
   output logic         req_tready,
   input  wire logic    out_free,
   output cmd_type      cmd
);

   localparam int IDX_W = $clog2(BUTTON_COUNT);
   localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(BUTTON_COUNT - 1);

   ctrl_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.button = INDEX_W'(scan_ff);
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = req_kind ? S_TICK_STEP : S_COUNT;
            end
         end
         S_COUNT: begin
            if (out_free) begin
               cmd.op   = OP_COUNT;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (out_free) begin
               cmd.op = OP_SCAN;
               if (scan_ff == SCAN_LAST) begin
                  scan_in  = '0;
                  state_in = S_RELCHK;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         S_RELCHK: begin
            if (out_free) begin
               cmd.op   = OP_RELCHK;
               state_in = S_HOLD_START;
            end
         end
         S_HOLD_START: begin
            if (out_free) begin
               cmd.op   = OP_HOLD_START;
               state_in = S_HOLD_SELECT;
            end
         end
         S_HOLD_SELECT: begin
            if (out_free) begin
               cmd.op   = OP_HOLD_SELECT;
               state_in = S_FLUSH;
            end
         end
         S_TICK_STEP: begin
            if (out_free) begin
               cmd.op   = OP_TICK_STEP;
               state_in = S_TICK_POWER;
            end
         end
         S_TICK_POWER: begin
            if (out_free) begin
               cmd.op   = OP_TICK_POWER;
               state_in = S_TICK_BIOS;
            end
         end
         S_TICK_BIOS: begin
            if (out_free) begin
               cmd.op   = OP_TICK_BIOS;
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               cmd.op   = OP_FLUSH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `BDE_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready, state_ff != S_IDLE, "request accepted but sequencer stayed idle")
   `BDE_ASSERT_NEXT(a_flush_returns_idle, clock, reset, (state_ff == S_FLUSH) && out_free, state_ff == S_IDLE, "flush did not return to idle")
   `BDE_ASSERT_IMPLY(a_scan_parked, clock, reset, state_ff != S_SCAN, scan_ff == '0, "scan counter not parked outside scan")

endmodule

`default_nettype wire

>>> src/bde_datapath.sv
// Datapath: config registers, per-button state and counts, timers, result staging.
// Depends on bde_pkg; steered by commands from bde_ctrl.
`default_nettype none

module bde_datapath
   import bde_pkg::*;
#(
   parameter int BUTTON_COUNT = BUTTON_COUNT_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   input  wire logic [RAW_W-1:0]        req_raw,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata,
   output logic                         out_free,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output result_type                   rsp_result,
   output logic                         rsp_last
);

   localparam int IDX_W = $clog2(BUTTON_COUNT);
   localparam int N     = BUTTON_COUNT;

   // config
   logic [THR_W-1:0]    cfg_thr_ff;
   logic [DELAY_W-1:0]  cfg_delay_ff;
   logic [UNITS_W-1:0]  cfg_units_ff;
   logic [IDLE_W-1:0]   cfg_idle_ff;
   logic [INDEX_W-1:0]  cfg_start_ff;
   logic [INDEX_W-1:0]  cfg_select_ff;

   // per-button lanes; head of the scan is lane 0, lanes rotate one per scan step
   btn_state_type       st_ff [N];
   btn_state_type       st_in [N];
   logic [CNT_W-1:0]    cnt_ff [N];
   logic [CNT_W-1:0]    cnt_in [N];
   logic [N-1:0]        raw_ff, raw_in;

   logic                pend_ff, pend_in;
   logic [DELAY_W-1:0]  rtimer_ff, rtimer_in;
   logic                parmed_ff, parmed_in;
   logic                prun_ff, prun_in;
   logic [PTIMER_W-1:0] ptimer_ff, ptimer_in;
   logic                barmed_ff, barmed_in;
   logic                brun_ff, brun_in;
   logic [BTIMER_W-1:0] btimer_ff, btimer_in;
   logic [IDLE_W-1:0]   idle_ff, idle_in;

   result_type          hold_ff, hold_in;
   logic                hold_valid_ff, hold_valid_in;
   result_type          out_ff, out_in;
   logic                out_last_ff, out_last_in;
   logic                out_valid_ff, out_valid_in;

   logic [THR_W-1:0]    thr_eff;
   logic [INDEX_W-1:0]  rd_idx;
   logic                rd_released;
   logic [PTIMER_W-1:0] pload;
   logic [BTIMER_W-1:0] bload;

   assign thr_eff  = (cfg_thr_ff == '0) ? THR_W'(1) : cfg_thr_ff;
   assign rd_idx   = (cmd.op == OP_HOLD_SELECT) ? cfg_select_ff : cfg_start_ff;
   assign pload    = PTIMER_W'(cfg_units_ff) * HOLD_UNIT_MS;
   assign bload    = {pload, 1'b0};
   assign out_free = !out_valid_ff || rsp_ready;

   // buttons named beyond the lanes read as released
   always_comb begin
      if ({1'b0, rd_idx} < (INDEX_W + 1)'(N)) begin
         rd_released = (st_ff[rd_idx[IDX_W-1:0]] == BTN_RELEASED);
      end else begin
         rd_released = 1'b1;
      end
   end

   always_comb begin
      btn_state_type       hs;
      logic [CNT_W-1:0]    hc;
      logic                is_start;
      logic                gen;
      result_type          gen_res;
      logic                flush;

      for (int j = 0; j < N; j++) begin
         st_in[j]  = st_ff[j];
         cnt_in[j] = cnt_ff[j];
      end
      raw_in    = raw_ff;
      pend_in   = pend_ff;
      rtimer_in = rtimer_ff;
      parmed_in = parmed_ff;
      prun_in   = prun_ff;
      ptimer_in = ptimer_ff;
      barmed_in = barmed_ff;
      brun_in   = brun_ff;
      btimer_in = btimer_ff;
      idle_in   = idle_ff;
      gen       = 1'b0;
      gen_res   = '{kind: EVT_BUTTON, button: '0, pressed: 1'b0};
      flush     = 1'b0;
      hs        = st_ff[0];
      hc        = cnt_ff[0];
      is_start  = (cmd.button == cfg_start_ff);

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            raw_in = req_raw[N-1:0];
         end
         OP_COUNT: begin
            for (int j = 0; j < N; j++) begin
               if ((st_ff[j] == BTN_RELEASED) == raw_ff[j]) begin
                  if (cnt_ff[j] != CNT_MAX) begin
                     cnt_in[j] = cnt_ff[j] + 1'b1;
                  end
               end else begin
                  cnt_in[j] = '0;
               end
            end
         end
         OP_SCAN: begin
            for (int j = 0; j < N - 1; j++) begin
               st_in[j]  = st_ff[j + 1];
               cnt_in[j] = cnt_ff[j + 1];
            end
            if (hc >= thr_eff) begin
               hc      = '0;
               hs      = (st_ff[0] == BTN_RELEASED) ? BTN_PRESSED : BTN_RELEASED;
               idle_in = '0;
               if (!(is_start && hs == BTN_RELEASED)) begin
                  gen     = 1'b1;
                  gen_res = '{kind: EVT_BUTTON, button: cmd.button,
                              pressed: (hs != BTN_RELEASED)};
               end
               if (is_start && hs == BTN_PRESSED) begin
                  hs        = BTN_LONG;
                  pend_in   = 1'b1;
                  rtimer_in = cfg_delay_ff;
               end
            end
            st_in[N-1]  = hs;
            cnt_in[N-1] = hc;
         end
         OP_RELCHK: begin
            if (pend_ff && rtimer_ff == '0) begin
               gen     = 1'b1;
               gen_res = '{kind: EVT_BUTTON, button: cfg_start_ff, pressed: 1'b0};
               pend_in = 1'b0;
            end
         end
         OP_HOLD_START: begin
            if (!parmed_ff && !rd_released) begin
               parmed_in = 1'b1;
               prun_in   = 1'b1;
               ptimer_in = pload;
            end else if (parmed_ff && rd_released) begin
               parmed_in = 1'b0;
               prun_in   = 1'b0;
               ptimer_in = '0;
            end
         end
         OP_HOLD_SELECT: begin
            if (!barmed_ff && !rd_released) begin
               barmed_in = 1'b1;
               brun_in   = 1'b1;
               btimer_in = bload;
            end else if (barmed_ff && rd_released) begin
               barmed_in = 1'b0;
               brun_in   = 1'b0;
               btimer_in = '0;
            end
         end
         OP_TICK_STEP: begin
            if (pend_ff && rtimer_ff != '0) begin
               rtimer_in = rtimer_ff - 1'b1;
            end
            if (prun_ff && ptimer_ff != '0) begin
               ptimer_in = ptimer_ff - 1'b1;
            end
            if (brun_ff && btimer_ff != '0) begin
               btimer_in = btimer_ff - 1'b1;
            end
            if (idle_ff != IDLE_MAX) begin
               idle_in = idle_ff + 1'b1;
            end
         end
         OP_TICK_POWER: begin
            if ((prun_ff && ptimer_ff == '0) || (idle_ff >= cfg_idle_ff)) begin
               prun_in   = 1'b0;
               ptimer_in = '0;
               idle_in   = '0;
               gen       = 1'b1;
               gen_res   = '{kind: EVT_POWER, button: '0, pressed: 1'b0};
            end
         end
         OP_TICK_BIOS: begin
            if (brun_ff && btimer_ff == '0) begin
               brun_in = 1'b0;
               gen     = 1'b1;
               gen_res = '{kind: EVT_BIOS, button: '0, pressed: 1'b0};
            end
         end
         OP_FLUSH: begin
            flush = 1'b1;
         end
         default: begin
         end
      endcase

      // one result is staged so the final one of a request can be marked last
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      if (gen) begin
         hold_in       = gen_res;
         hold_valid_in = 1'b1;
         if (hold_valid_ff) begin
            out_in       = hold_ff;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
         end
      end else if (flush && hold_valid_ff) begin
         out_in        = hold_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_thr_ff    <= RST_THRESHOLD;
         cfg_delay_ff  <= RST_RELEASE;
         cfg_units_ff  <= RST_HOLD;
         cfg_idle_ff   <= RST_IDLE;
         cfg_start_ff  <= RST_START;
         cfg_select_ff <= RST_SELECT;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_THRESHOLD: cfg_thr_ff    <= csr_wdata[THR_W-1:0];
            REG_RELEASE:   cfg_delay_ff  <= csr_wdata[DELAY_W-1:0];
            REG_HOLD:      cfg_units_ff  <= csr_wdata[UNITS_W-1:0];
            REG_IDLE:      cfg_idle_ff   <= csr_wdata[IDLE_W-1:0];
            REG_START:     cfg_start_ff  <= csr_wdata[INDEX_W-1:0];
            REG_SELECT:    cfg_select_ff <= csr_wdata[INDEX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < N; j++) begin
            st_ff[j]  <= BTN_RELEASED;
            cnt_ff[j] <= '0;
         end
         pend_ff       <= 1'b0;
         rtimer_ff     <= '0;
         parmed_ff     <= 1'b0;
         prun_ff       <= 1'b0;
         ptimer_ff     <= '0;
         barmed_ff     <= 1'b0;
         brun_ff       <= 1'b0;
         btimer_ff     <= '0;
         idle_ff       <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         for (int j = 0; j < N; j++) begin
            st_ff[j]  <= st_in[j];
            cnt_ff[j] <= cnt_in[j];
         end
         pend_ff       <= pend_in;
         rtimer_ff     <= rtimer_in;
         parmed_ff     <= parmed_in;
         prun_ff       <= prun_in;
         ptimer_ff     <= ptimer_in;
         barmed_ff     <= barmed_in;
         brun_ff       <= brun_in;
         btimer_ff     <= btimer_in;
         idle_ff       <= idle_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;
   assign rsp_last   = out_last_ff;

endmodule

`default_nettype wire

>>> src/button_debounce_event_generator.sv
// Top level of the button debounce event generator: ports, packing, wiring.
// Depends on bde_pkg, bde_ctrl and bde_datapath.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser: kind; tdata: raw_buttons
//   rsp      out  rsp_tvalid/rsp_tready  tuser: event_kind; tdata: button_index,
//                                        pressed; tlast: last
//   csr      in   csr_we                 csr_index, csr_wdata
//
// A sample request runs count, one scan step per button, release and hold checks,
// then flush; a tick request runs timer step, power and BIOS checks, then flush.
// Each step waits while the output register holds a result not yet taken.
// Synchronous reset clears the state and count of every button and all timers.
// Results are staged one deep so the final one of a request carries tlast.
`default_nettype none

module button_debounce_event_generator
   import bde_pkg::*;
#(
   parameter int BUTTON_COUNT = BUTTON_COUNT_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [15:0]             req_tdata,   // [15:0] raw_buttons
   input  wire logic [0:0]              req_tuser,   // [0] kind
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [3:0] button_index, [4] pressed
   output logic [1:0]                   rsp_tuser,   // [1:0] event_kind
   output logic                         rsp_tlast,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   cmd_type     cmd;
   logic        out_free;
   result_type  result;

   bde_ctrl #(
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser[0]),
      .req_tready (req_tready),
      .out_free   (out_free),
      .cmd        (cmd)
   );

   bde_datapath #(
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_raw    (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .out_free   (out_free),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, result.pressed, result.button};
   assign rsp_tuser = result.kind;

endmodule

`default_nettype wire
